// ===== rtl/volume_gradient_difference_top_assert.svh =====
// Assertion macros used by the volume gradient difference control.
`ifndef VOLUME_GRADIENT_DIFFERENCE_TOP_ASSERT_SVH
`define VOLUME_GRADIENT_DIFFERENCE_TOP_ASSERT_SVH

// The condition must hold on the same clock edge as the antecedent.
`define VGD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The condition must hold on the clock edge after the antecedent.
`define VGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/vgd_pkg.sv =====
// Shared types and constants of the volume gradient difference block.
`timescale 1ns / 1ps

package vgd_pkg;

    // Fixed field widths of the ports.
    localparam int INDEX_BITS = 21;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS   = 2'd0,
        REG_SIZE_X = 2'd1,
        REG_SIZE_Y = 2'd2,
        REG_SIZE_Z = 2'd3
    } t_reg;

    // Axis codes.
    localparam logic [1:0] AXIS_ROW   = 2'd0;
    localparam logic [1:0] AXIS_COL   = 2'd1;
    localparam logic [1:0] AXIS_PLANE = 2'd2;

    // Input opcodes.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register reset values.
    localparam logic [1:0]            AXIS_RESET = AXIS_ROW;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 8'd128;

    // Cycles for the derived sizes to settle after a configuration write.
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // How the difference of one item is formed.
    typedef enum logic [1:0] {
        K_PUSH_FIRST,   // new sample minus the sample one stride back
        K_PUSH_LATER,   // new sample minus the sample two strides back
        K_FLUSH,        // stored voxel minus the voxel one stride before it
        K_ERROR         // invalid geometry: zero with the error flag
    } t_kind;

    // Request passed from the control to the difference stage.
    typedef struct packed {
        logic                  have;
        t_kind                 kind;
        logic [INDEX_BITS-1:0] index;
        logic                  last;
    } t_req;

endpackage

// ===== rtl/vgd_channels_if.sv =====
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface vgd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface vgd_out_if
    import vgd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] difference;
    logic [INDEX_BITS-1:0]       voxel_index;
    logic                        last;
    logic                        config_error;

    modport source (output valid, output difference, output voxel_index, output last,
                    output config_error, input ready);
    modport sink   (input valid, input difference, input voxel_index, input last,
                    input config_error, output ready);
endinterface

// ===== rtl/vgd_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module vgd_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32768,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Reads return the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/vgd_ctrl.sv =====
// Configuration, volume counters and window addressing of the gradient block.
`timescale 1ns / 1ps
`include "volume_gradient_difference_top_assert.svh"

module vgd_ctrl
    import vgd_pkg::*;
#(
    parameter int MAX_SIDE    = 128,
    parameter int SAMPLE_BITS = 16,
    localparam int DEPTH      = 2 * MAX_SIDE * MAX_SIDE,
    localparam int ADDR_W     = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    vgd_in_if.sink                 i_in,
    input  logic                   i_s1_free,
    output logic                   o_ram_we,
    output logic                   o_ram_re,
    output logic [ADDR_W-1:0]      o_ram_waddr,
    output logic [ADDR_W-1:0]      o_ram_raddr_a,
    output logic [ADDR_W-1:0]      o_ram_raddr_b,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_req_valid,
    output t_req                   o_req
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ST_W   = 2 * SIDE_W;
    localparam int SP_W   = ST_W + 1;
    localparam int N_W    = 3 * SIDE_W;
    localparam int CW     = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;

    // Saturate a raw size register into 1 .. MAX_SIDE.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0) begin
            clamp_side = SIDE_W'(1);
        end else if (w > CW'(MAX_SIDE)) begin
            clamp_side = SIDE_W'(MAX_SIDE);
        end else begin
            clamp_side = SIDE_W'(w);
        end
    endfunction

    logic [1:0]            r_axis;
    logic [CFG_DATA_W-1:0] r_size_x;
    logic [CFG_DATA_W-1:0] r_size_y;
    logic [CFG_DATA_W-1:0] r_size_z;
    logic [1:0]            r_settle;

    logic [1:0]            r_axis_d;
    logic [SIDE_W-1:0]     r_sy_c;
    logic [SIDE_W-1:0]     r_sz_c;
    logic [ST_W-1:0]       r_sxy;
    logic [ST_W-1:0]       r_stride;
    logic [N_W-1:0]        r_n;
    logic                  r_err;

    logic [N_W-1:0]        r_recv;
    logic [ST_W-1:0]       r_flushed;
    logic [ADDR_W-1:0]     r_wptr;
    logic [N_W-1:0]        n_recv;
    logic [ST_W-1:0]       n_flushed;
    logic [ADDR_W-1:0]     n_wptr;

    logic [SIDE_W-1:0]     w_sx;
    logic [SIDE_W-1:0]     w_sy;
    logic [SIDE_W-1:0]     w_sz;
    logic [SP_W-1:0]       w_span;
    logic                  w_ready;
    logic                  w_acc;
    logic                  w_push_ok;
    logic                  w_have;
    logic                  w_first;
    logic                  w_flush_ok;
    logic [ST_W-1:0]       w_f_inc;
    logic                  w_last;
    logic [SP_W-1:0]       w_wp_ext;
    logic [SP_W-1:0]       w_st_ext;
    logic [SP_W-1:0]       w_wp_inc;
    logic [ADDR_W-1:0]     w_wptr_next;
    logic [SP_W-1:0]       w_back;
    logic [INDEX_BITS-1:0] w_push_idx;
    logic [INDEX_BITS-1:0] w_flush_idx;
    t_req                  w_req;
    logic                  w_we;
    logic                  w_re;

    // Configuration registers, settle counter and volume counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis    <= AXIS_RESET;
            r_size_x  <= SIZE_RESET;
            r_size_y  <= SIZE_RESET;
            r_size_z  <= SIZE_RESET;
            r_settle  <= SETTLE_CYCLES;
            r_recv    <= '0;
            r_flushed <= '0;
            r_wptr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AXIS:   r_axis   <= i_cfg_data[1:0];
                    REG_SIZE_X: r_size_x <= i_cfg_data;
                    REG_SIZE_Y: r_size_y <= i_cfg_data;
                    REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= SETTLE_CYCLES;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 2'd1;
            end
            r_recv    <= n_recv;
            r_flushed <= n_flushed;
            r_wptr    <= n_wptr;
        end
    end

    // Derived geometry, at most one multiplication per register stage.
    assign w_sx   = clamp_side(r_size_x);
    assign w_sy   = clamp_side(r_size_y);
    assign w_sz   = clamp_side(r_size_z);
    assign w_span = {r_stride, 1'b0};

    always_ff @(posedge i_clk) begin
        r_axis_d <= r_axis;
        r_sy_c   <= w_sy;
        r_sz_c   <= w_sz;
        r_sxy    <= ST_W'(w_sx) * ST_W'(w_sy);
        r_n      <= N_W'(r_sxy) * N_W'(r_sz_c);
        case (r_axis_d)
            AXIS_COL:   r_stride <= ST_W'(r_sy_c);
            AXIS_PLANE: r_stride <= r_sxy;
            default:    r_stride <= ST_W'(1);
        endcase
        r_err    <= N_W'(w_span) > r_n;
    end

    // Handshake: hold off while the derived sizes settle or the next stage is full.
    assign w_ready    = i_s1_free && (r_settle == '0);
    assign i_in.ready = w_ready;
    assign w_acc      = i_in.valid && w_ready;

    // Position tests on the flat index.
    assign w_push_ok  = r_recv < r_n;
    assign w_have     = r_recv >= N_W'(r_stride);
    assign w_first    = r_recv < N_W'(w_span);
    assign w_flush_ok = (r_recv >= r_n) && (r_flushed < r_stride);
    assign w_f_inc    = r_flushed + ST_W'(1);
    assign w_last     = w_f_inc >= r_stride;

    // Ring pointer arithmetic modulo twice the stride.
    assign w_wp_ext    = SP_W'(r_wptr);
    assign w_st_ext    = SP_W'(r_stride);
    assign w_wp_inc    = w_wp_ext + SP_W'(1);
    assign w_wptr_next = (w_wp_inc == w_span) ? '0 : ADDR_W'(w_wp_inc);
    assign w_back      = (w_wp_ext >= w_st_ext) ? (w_wp_ext - w_st_ext)
                                                : (w_wp_ext + w_st_ext);

    assign w_push_idx  = INDEX_BITS'(r_recv - N_W'(r_stride));
    assign w_flush_idx = INDEX_BITS'(r_n - N_W'(r_stride) + N_W'(r_flushed));

    // Per-item decision and next counter values.
    always_comb begin
        n_recv      = r_recv;
        n_flushed   = r_flushed;
        n_wptr      = r_wptr;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_req.have  = 1'b0;
        w_req.kind  = K_ERROR;
        w_req.index = '0;
        w_req.last  = 1'b0;
        if (w_acc) begin
            if (r_err) begin
                w_req.have = 1'b1;
            end else if (i_in.opcode == OP_PUSH) begin
                if (w_push_ok) begin
                    w_we        = 1'b1;
                    w_re        = 1'b1;
                    w_req.have  = w_have;
                    w_req.kind  = w_first ? K_PUSH_FIRST : K_PUSH_LATER;
                    w_req.index = w_push_idx;
                    n_recv      = r_recv + N_W'(1);
                    n_wptr      = w_wptr_next;
                end
            end else begin
                if (w_flush_ok) begin
                    w_re        = 1'b1;
                    w_req.have  = 1'b1;
                    w_req.kind  = K_FLUSH;
                    w_req.index = w_flush_idx;
                    w_req.last  = w_last;
                    if (w_last) begin
                        n_recv    = '0;
                        n_flushed = '0;
                        n_wptr    = '0;
                    end else begin
                        n_flushed = w_f_inc;
                        n_wptr    = w_wptr_next;
                    end
                end
            end
        end
        // Any register write starts a new volume.
        if (i_cfg_we) begin
            n_recv    = '0;
            n_flushed = '0;
            n_wptr    = '0;
        end
    end

    assign o_ram_we      = w_we;
    assign o_ram_re      = w_re;
    assign o_ram_waddr   = r_wptr;
    assign o_ram_raddr_a = ADDR_W'(w_back);
    assign o_ram_raddr_b = r_wptr;
    assign o_sample      = i_in.sample;
    assign o_req_valid   = w_acc && w_req.have;
    assign o_req         = w_req;

    // Invariants of the counters and the ring pointer.
    `VGD_ASSERT_IMPLY(a_wptr_in_span, (r_settle == '0) && !r_err, w_wp_ext < w_span)
    `VGD_ASSERT_IMPLY(a_recv_bound, r_settle == '0, r_recv <= r_n)
    `VGD_ASSERT_IMPLY(a_flush_bound, (r_settle == '0) && !r_err, r_flushed < r_stride)
    `VGD_ASSERT_NEXT(a_cfg_restarts, i_cfg_we, (r_recv == '0) && (r_flushed == '0) && !w_ready)

endmodule

// ===== rtl/vgd_diff.sv =====
// Difference stage and output register of the gradient block.
`timescale 1ns / 1ps

module vgd_diff
    import vgd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  t_req                   i_req,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_rdata_a,
    input  logic [SAMPLE_BITS-1:0] i_rdata_b,
    output logic                   o_s1_free,
    vgd_out_if.source              o_out
);

    localparam int DW = SAMPLE_BITS + 1;

    logic                   r_s1_valid;
    t_req                   r_s1_req;
    logic [SAMPLE_BITS-1:0] r_s1_sample;

    logic                   r_out_valid;
    logic signed [DW-1:0]   r_out_diff;
    logic [INDEX_BITS-1:0]  r_out_index;
    logic                   r_out_last;
    logic                   r_out_err;

    logic                   w_advance;
    logic signed [DW-1:0]   w_new;
    logic signed [DW-1:0]   w_a;
    logic signed [DW-1:0]   w_b;
    logic signed [DW-1:0]   w_diff;

    // The request waits here for the window read or a full output.
    assign w_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_s1_free = !r_s1_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s1_free) begin
            r_s1_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_free) begin
            r_s1_req    <= i_req;
            r_s1_sample <= i_sample;
        end
    end

    // Sign-extended operands and the difference chosen by the item kind.
    assign w_new = {r_s1_sample[SAMPLE_BITS-1], r_s1_sample};
    assign w_a   = {i_rdata_a[SAMPLE_BITS-1], i_rdata_a};
    assign w_b   = {i_rdata_b[SAMPLE_BITS-1], i_rdata_b};

    always_comb begin
        case (r_s1_req.kind)
            K_PUSH_FIRST: w_diff = w_new - w_a;
            K_PUSH_LATER: w_diff = w_new - w_b;
            K_FLUSH:      w_diff = w_a - w_b;
            default:      w_diff = '0;
        endcase
    end

    // Output register, refilled as soon as the held item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_diff  <= w_diff;
            r_out_index <= r_s1_req.index;
            r_out_last  <= r_s1_req.last;
            r_out_err   <= (r_s1_req.kind == K_ERROR);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.difference   = r_out_diff;
    assign o_out.voxel_index  = r_out_index;
    assign o_out.last         = r_out_last;
    assign o_out.config_error = r_out_err;

endmodule

// ===== rtl/volume_gradient_difference_top.sv =====
// Top level of the volume gradient difference block.
`timescale 1ns / 1ps

// Streams flat-ordered voxels and returns the unscaled difference along the
// selected axis. One item is accepted every clock cycle while the output is not
// stalled, both push and flush items; each result passes through the request
// register and then the output register, as the sample window is a memory with
// one write port and two registered read ports that is read in the accept cycle
// and subtracted in the next. After each configuration write, and after reset,
// the input is held off while the stride and the voxel count are recomputed
// through two registered multiplications. Results lag the pushes by one stride;
// the last stride's worth of results come out one per flush item.
// The window is not cleared after reset, as only entries written in the current
// volume are ever used in a result.
module volume_gradient_difference_top
    import vgd_pkg::*;
#(
    parameter int MAX_SIDE    = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vgd_in_if.sink                i_in,
    vgd_out_if.source             o_out
);

    localparam int DEPTH  = 2 * MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [ADDR_W-1:0]      w_ram_waddr;
    logic [ADDR_W-1:0]      w_ram_raddr_a;
    logic [ADDR_W-1:0]      w_ram_raddr_b;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0] w_rdata_a;
    logic [SAMPLE_BITS-1:0] w_rdata_b;
    logic                   w_req_valid;
    t_req                   w_req;
    logic                   w_s1_free;

    // Counters, configuration and window addressing.
    vgd_ctrl #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in          (i_in),
        .i_s1_free     (w_s1_free),
        .o_ram_we      (w_ram_we),
        .o_ram_re      (w_ram_re),
        .o_ram_waddr   (w_ram_waddr),
        .o_ram_raddr_a (w_ram_raddr_a),
        .o_ram_raddr_b (w_ram_raddr_b),
        .o_sample      (w_sample),
        .o_req_valid   (w_req_valid),
        .o_req         (w_req)
    );

    // Ring of the most recent samples.
    vgd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (w_ram_waddr),
        .i_wdata   (w_sample),
        .i_re      (w_ram_re),
        .i_raddr_a (w_ram_raddr_a),
        .i_raddr_b (w_ram_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Subtraction and result register.
    vgd_diff #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .i_sample    (w_sample),
        .i_rdata_a   (w_rdata_a),
        .i_rdata_b   (w_rdata_b),
        .o_s1_free   (w_s1_free),
        .o_out       (o_out)
    );

endmodule

// ===== verif/tb_volume_gradient_difference_top.sv =====
// Self-checking testbench of the volume gradient difference block.
`timescale 1ns / 1ps

module tb_volume_gradient_difference_top;
    import vgd_pkg::*;

    localparam int MAX_SIDE       = 128;
    localparam int SAMPLE_BITS    = 16;
    localparam int WINDOW_DEPTH   = 2 * MAX_SIDE * MAX_SIDE;
    localparam int RANDOM_ITEMS   = 150;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    // The fourth axis code is unused and behaves as the row axis.
    localparam logic [1:0] AXIS_SPARE = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    // How busy both sides are while a phase runs.
    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} t_pace;

    typedef struct {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample;
        int                            gap;
    } t_voxel_item;

    typedef struct {
        logic signed [SAMPLE_BITS:0] difference;
        logic [INDEX_BITS-1:0]       voxel_index;
        logic                        last;
        logic                        config_error;
    } t_gradient;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vgd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    vgd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    volume_gradient_difference_top #(
        .MAX_SIDE    (MAX_SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch),
        .o_out      (result_ch)
    );

    // Item and result bookkeeping.
    t_voxel_item voxel_feed[$];
    t_gradient   gradient_expect[$];
    int          fed_total = 0;
    int          taken_total = 0;
    int          mismatches = 0;
    t_pace       pace = PACE_LIGHT;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          feed_wait = 0;
    int          hold_asks = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    // Predictor copy of the registers and the volume state.
    logic [1:0]                    axis_m;
    logic [CFG_DATA_W-1:0]         side_x_m;
    logic [CFG_DATA_W-1:0]         side_y_m;
    logic [CFG_DATA_W-1:0]         side_z_m;
    logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_DEPTH];
    int                            received_m;
    int                            flushed_m;

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_side(logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic int stride_now();
        case (axis_m)
            AXIS_COL:   return clamp_side(side_y_m);
            AXIS_PLANE: return clamp_side(side_x_m) * clamp_side(side_y_m);
            default:    return 1;
        endcase
    endfunction

    function automatic int voxels_now();
        return clamp_side(side_x_m) * clamp_side(side_y_m) * clamp_side(side_z_m);
    endfunction

    // Any register write starts a new volume.
    function automatic void apply_register(t_reg r, logic [CFG_DATA_W-1:0] d);
        case (r)
            REG_AXIS:   axis_m   = d[1:0];
            REG_SIZE_X: side_x_m = d;
            REG_SIZE_Y: side_y_m = d;
            default:    side_z_m = d;
        endcase
        received_m = 0;
        flushed_m  = 0;
    endfunction

    // Works out the gradient result, if any, that one accepted item causes.
    function automatic void predict_gradient(logic opcode,
                                             logic signed [SAMPLE_BITS-1:0] sample);
        int        s;
        int        n;
        int        span;
        int        j;
        int        diff;
        t_gradient r;
        s    = stride_now();
        n    = voxels_now();
        span = 2 * s;
        r    = '{difference: '0, voxel_index: '0, last: 1'b0, config_error: 1'b0};
        if (span > n) begin
            // Invalid geometry: every item gives a zero with the error flag.
            r.config_error = 1'b1;
            gradient_expect.push_back(r);
        end else if (opcode == OP_PUSH) begin
            if (received_m < n) begin
                if (received_m >= s) begin
                    j = received_m - s;
                    // Read before the write, as both may fall on the same slot.
                    if (j < s) diff = int'(sample) - int'(window_mem[j]);
                    else diff = int'(sample) - int'(window_mem[(received_m - span) % span]);
                    r.difference  = diff[SAMPLE_BITS:0];
                    r.voxel_index = j[INDEX_BITS-1:0];
                    gradient_expect.push_back(r);
                end
                window_mem[received_m % span] = sample;
                received_m++;
            end
        end else if (received_m >= n && flushed_m < s) begin
            j    = n - s + flushed_m;
            diff = int'(window_mem[j % span]) - int'(window_mem[(j - s) % span]);
            r.difference  = diff[SAMPLE_BITS:0];
            r.voxel_index = j[INDEX_BITS-1:0];
            r.last        = (j == n - 1);
            flushed_m++;
            if (flushed_m >= s) begin
                received_m = 0;
                flushed_m  = 0;
            end
            gradient_expect.push_back(r);
        end
    endfunction

    function automatic void check_gradient(t_gradient want, t_gradient got);
        if (got.difference !== want.difference) begin
            $error("difference: expected %0d, got %0d", want.difference, got.difference);
            mismatches++;
        end
        if (got.voxel_index !== want.voxel_index) begin
            $error("voxel_index: expected %0d, got %0d", want.voxel_index, got.voxel_index);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
        end
        if (got.config_error !== want.config_error) begin
            $error("config_error: expected %0b, got %0b", want.config_error,
                   got.config_error);
            mismatches++;
        end
    endfunction

    function automatic int draw_gap();
        case (pace)
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default:    return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void queue_item(logic opcode, logic signed [SAMPLE_BITS-1:0] sample);
        t_voxel_item it;
        it.opcode = opcode;
        it.sample = sample;
        it.gap    = draw_gap();
        voxel_feed.push_back(it);
        fed_total++;
    endfunction

    // Queues one volume: all pushes, then a stride's worth of flushes. When noisy, the
    // volume may be abandoned part way, and stray flushes and pushes are mixed in.
    // Returns 0 when the volume was abandoned.
    function automatic bit queue_volume(bit noisy);
        int n;
        int s;
        int cut;
        int k;
        n   = voxels_now();
        s   = stride_now();
        cut = n;
        if (noisy && $urandom_range(0, 9) == 0) cut = $urandom_range(0, n - 1);
        if (noisy && $urandom_range(0, 7) == 0) queue_item(OP_FLUSH, draw_sample());
        for (k = 0; k < cut; k++) begin
            queue_item(OP_PUSH, draw_sample());
            if (noisy && $urandom_range(0, 63) == 0) queue_item(OP_FLUSH, draw_sample());
        end
        if (cut < n) return 1'b0;
        if (noisy && $urandom_range(0, 3) == 0) queue_item(OP_PUSH, draw_sample());
        for (k = 0; k < s; k++) queue_item(OP_FLUSH, draw_sample());
        if (noisy && $urandom_range(0, 3) == 0) queue_item(OP_FLUSH, draw_sample());
        return 1'b1;
    endfunction

    task automatic wait_drained();
        while (taken_total != fed_total || gradient_expect.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg r, logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        apply_register(r, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic program_volume(logic [CFG_DATA_W-1:0] axis_d, logic [CFG_DATA_W-1:0] sx,
                                  logic [CFG_DATA_W-1:0] sy, logic [CFG_DATA_W-1:0] sz);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_register(REG_AXIS, axis_d);
        write_register(REG_SIZE_X, sx);
        write_register(REG_SIZE_Y, sy);
        write_register(REG_SIZE_Z, sz);
    endtask

    // One random geometry, mostly small, now and then with one long side.
    task automatic random_phase();
        logic [CFG_DATA_W-1:0] sides [3];
        int                    big;
        int                    vols;
        int                    d;
        bit                    long_side;
        long_side = 1'b0;
        for (d = 0; d < 3; d++) begin
            sides[d] = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
        end
        if ($urandom_range(0, 7) == 0) begin
            big = $urandom_range(0, 2);
            for (d = 0; d < 3; d++) begin
                sides[d] = (d == big) ? 8'($urandom_range(6, 255)) : 8'd1;
            end
            long_side = 1'b1;
        end
        program_volume(8'($urandom_range(0, 255)), sides[0], sides[1], sides[2]);
        pace = t_pace'($urandom_range(0, 2));
        if (2 * stride_now() > voxels_now()) begin
            repeat ($urandom_range(3, 8)) begin
                queue_item($urandom_range(0, 1) ? OP_FLUSH : OP_PUSH, draw_sample());
            end
        end else begin
            // A long side gets a single volume so that the item count stays modest.
            vols = long_side ? 1 : $urandom_range(1, 3);
            while (vols > 0 && queue_volume(1'b1)) vols--;
        end
    endtask

    // Driver: offers the next pending item after its gap, holds it until taken.
    always @(negedge i_clk) begin
        logic        valid_next;
        t_voxel_item it;
        if (!i_rst_n) begin
            feed_wait  = 0;
            valid_next = 1'b0;
        end else begin
            valid_next = sample_ch.valid && !in_taken;
            if (!valid_next && voxel_feed.size() > 0) begin
                if (feed_wait < voxel_feed[0].gap) begin
                    feed_wait++;
                end else begin
                    it               = voxel_feed.pop_front();
                    feed_wait        = 0;
                    sample_ch.opcode <= it.opcode;
                    sample_ch.sample <= it.sample;
                    valid_next       = 1'b1;
                end
            end
        end
        sample_ch.valid <= valid_next;
    end

    // Receiver: may stall after each result, and stalls for a long stretch when asked.
    always @(negedge i_clk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (!i_rst_n) begin
            hold_left  = 0;
            stall_left = 0;
            ready_next = 1'b0;
        end else begin
            if (hold_asks != hold_served) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (out_taken) stall_left = draw_gap();
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end
        end
        result_ch.ready <= ready_next;
    end

    // Monitor: predicts on each accepted item, checks each accepted result.
    always @(posedge i_clk) begin
        t_gradient got;
        t_gradient want;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            out_taken    <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken  <= sample_ch.valid && sample_ch.ready;
            out_taken <= result_ch.valid && result_ch.ready;
            if (result_ch.valid && result_ch.ready) begin
                got.difference   = result_ch.difference;
                got.voxel_index  = result_ch.voxel_index;
                got.last         = result_ch.last;
                got.config_error = result_ch.config_error;
                if (gradient_expect.size() == 0) begin
                    $error("result for voxel %0d with none expected", got.voxel_index);
                    mismatches++;
                end else begin
                    want = gradient_expect.pop_front();
                    check_gradient(want, got);
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                predict_gradient(sample_ch.opcode, sample_ch.sample);
                taken_total++;
            end
            // Watchdog on cycles in which nothing moves.
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                    || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** volume_gradient_difference_top: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus.
    initial begin
        int fed_mark;
        int k;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_AXIS;
        i_cfg_data       = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.opcode = OP_PUSH;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        axis_m           = AXIS_RESET;
        side_x_m         = SIZE_RESET;
        side_y_m         = SIZE_RESET;
        side_z_m         = SIZE_RESET;
        received_m       = 0;
        flushed_m        = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: extreme samples give the largest differences of both
        // signs, then a flush long before the volume is complete.
        queue_item(OP_PUSH, SAMPLE_MAX);
        queue_item(OP_PUSH, SAMPLE_MIN);
        queue_item(OP_PUSH, SAMPLE_MIN);
        queue_item(OP_PUSH, SAMPLE_MAX);
        queue_item(OP_FLUSH, SAMPLE_MAX);

        // A single voxel (zero side saturated to one): push and flush both flag
        // the geometry error.
        program_volume({6'd0, AXIS_ROW}, 8'd0, 8'd1, 8'd1);
        queue_item(OP_PUSH, 16'sh1234);
        queue_item(OP_FLUSH, SAMPLE_MIN);

        // Spare axis code with the upper data bits set: a push past the end of the
        // volume, the flush of the last voxel, then a flush with nothing pending.
        program_volume({6'h3F, AXIS_SPARE}, 8'd3, 8'd1, 8'd2);
        for (k = 0; k < 7; k++) queue_item(OP_PUSH, draw_sample());
        queue_item(OP_FLUSH, '0);
        queue_item(OP_FLUSH, '0);

        // Column axis where twice the stride equals the voxel count.
        program_volume({6'd0, AXIS_COL}, 8'd2, 8'd3, 8'd1);
        void'(queue_volume(1'b0));

        // Plane axis, where the window holds two whole planes.
        pace = PACE_FULL;
        program_volume({6'd0, AXIS_PLANE}, 8'd4, 8'd5, 8'd2);
        void'(queue_volume(1'b0));

        // Longest z side, saturated, on the column axis.
        program_volume({6'd0, AXIS_COL}, 8'd1, 8'd1, 8'd200);
        pace = PACE_HEAVY;
        void'(queue_volume(1'b0));

        // Results held back while items keep coming, then the sender waits for
        // every result before finishing the volume.
        program_volume({6'd0, AXIS_ROW}, 8'd4, 8'd4, 8'd2);
        pace = PACE_FULL;
        hold_asks <= hold_asks + 1;
        for (k = 0; k < 20; k++) queue_item(OP_PUSH, draw_sample());
        wait_drained();
        for (k = 0; k < 12; k++) queue_item(OP_PUSH, draw_sample());
        queue_item(OP_FLUSH, draw_sample());

        // Random geometries and volumes.
        fed_mark = fed_total;
        while (fed_total - fed_mark < RANDOM_ITEMS) random_phase();

        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("** volume_gradient_difference_top: PASSED **");
        end else begin
            $display("** volume_gradient_difference_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vgd_pkg.sv
rtl/vgd_channels_if.sv
rtl/vgd_ram.sv
rtl/vgd_ctrl.sv
rtl/vgd_diff.sv
rtl/volume_gradient_difference_top.sv
verif/tb_volume_gradient_difference_top.sv
